// File: hdl/gre_tunnel_header_parser_assert.svh
// Assertion macros used by the parser top module.
`ifndef GRE_TUNNEL_HEADER_PARSER_ASSERT_SVH
`define GRE_TUNNEL_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GTP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication, disabled during reset.
`define GTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

// File: hdl/gtp_pkg.sv
package gtp_pkg;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_GRE = 8'd47;
  localparam logic [15:0] TYPE_TEB  = 16'h6558;

  localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
  localparam logic [4:0]  GRE_BASE_BYTES = 5'd4;
  localparam logic [4:0]  GRE_OPT_BYTES  = 5'd4;
  localparam logic [6:0]  POS_MAX        = 7'd127;

  // Byte offsets inside the IPv4 and GRE headers
  localparam logic [6:0]  IP_PROTO_OFS   = 7'd9;
  localparam logic [6:0]  IP_SRC_FIRST   = 7'd12;
  localparam logic [6:0]  IP_SRC_LAST    = 7'd15;
  localparam logic [6:0]  IP_DST_FIRST   = 7'd16;
  localparam logic [6:0]  IP_DST_LAST    = 7'd19;
  localparam logic [6:0]  GRE_PROTO_HI   = 7'd2;
  localparam logic [6:0]  GRE_PROTO_LO   = 7'd3;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  // Parse phases
  localparam logic [2:0]  PH_OUTER = 3'd0;
  localparam logic [2:0]  PH_IP    = 3'd1;
  localparam logic [2:0]  PH_GRE   = 3'd2;
  localparam logic [2:0]  PH_INNER = 3'd3;
  localparam logic [2:0]  PH_DONE  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        tunnel_ok;
    logic [31:0] outer_src_ip;
    logic [31:0] outer_dst_ip;
  } result_t;

endpackage

// File: hdl/gtp_in_stage.sv
module gtp_in_stage
  import gtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       advance,
  output logic       hold_vld,
  output item_t      hold_item
);

  assign s_tready = !hold_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (s_tready) begin
      hold_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_item.data_byte <= s_tdata;
      hold_item.last_byte <= s_tlast;
    end
  end

endmodule

// File: hdl/gtp_parse.sv
module gtp_parse
  import gtp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  logic [6:0]  byte_position, byte_position_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [5:0]  ip_header_bytes, ip_header_bytes_next;
  logic [4:0]  gre_header_bytes, gre_header_bytes_next;
  logic [15:0] field_shift, field_shift_next;
  logic [31:0] captured_src, captured_src_next;
  logic [31:0] captured_dst, captured_dst_next;
  logic        reject_flag, reject_flag_next;
  logic        complete_flag, complete_flag_next;

  logic [6:0]  ofs_ip, ofs_gre, ofs_inner;
  logic [7:0]  b;
  logic        ok;

  assign b         = item.data_byte;
  assign ofs_ip    = byte_position - ETH_HDR_BYTES;
  assign ofs_gre   = ofs_ip - {1'b0, ip_header_bytes};
  assign ofs_inner = ofs_gre - {2'b00, gre_header_bytes};

  always_comb begin
    byte_position_next    = (byte_position == POS_MAX) ? POS_MAX : byte_position + 7'd1;
    parse_phase_next      = parse_phase;
    ip_header_bytes_next  = ip_header_bytes;
    gre_header_bytes_next = gre_header_bytes;
    field_shift_next      = field_shift;
    captured_src_next     = captured_src;
    captured_dst_next     = captured_dst;
    reject_flag_next      = reject_flag;
    complete_flag_next    = complete_flag;
    if (!reject_flag) begin
      case (parse_phase)
        PH_OUTER: begin
          field_shift_next = {field_shift[7:0], b};
          if (byte_position == ETH_HDR_BYTES - 7'd1) begin
            if (field_shift_next != TYPE_IPV4) begin
              reject_flag_next = 1'b1;
            end else begin
              parse_phase_next = PH_IP;
            end
          end
        end
        PH_IP: begin
          if (ofs_ip == 7'd0) begin
            if (b[3:0] < IHL_MIN) begin
              reject_flag_next = 1'b1;
            end else begin
              ip_header_bytes_next = {b[3:0], 2'b00};
            end
          end else if (ofs_ip == IP_PROTO_OFS) begin
            if (b != PROTO_GRE) begin
              reject_flag_next = 1'b1;
            end
          end else if (ofs_ip >= IP_SRC_FIRST && ofs_ip <= IP_SRC_LAST) begin
            captured_src_next = {captured_src[23:0], b};
          end else if (ofs_ip >= IP_DST_FIRST && ofs_ip <= IP_DST_LAST) begin
            captured_dst_next = {captured_dst[23:0], b};
          end
          if (!reject_flag_next && (ofs_ip + 7'd1) == {1'b0, ip_header_bytes}) begin
            parse_phase_next = PH_GRE;
          end
        end
        PH_GRE: begin
          if (ofs_gre == 7'd0) begin
            gre_header_bytes_next = GRE_BASE_BYTES
                                  + (b[7] ? GRE_OPT_BYTES : 5'd0)
                                  + (b[5] ? GRE_OPT_BYTES : 5'd0)
                                  + (b[4] ? GRE_OPT_BYTES : 5'd0);
          end else if (ofs_gre == GRE_PROTO_HI || ofs_gre == GRE_PROTO_LO) begin
            field_shift_next = {field_shift[7:0], b};
            if (ofs_gre == GRE_PROTO_LO && field_shift_next != TYPE_TEB) begin
              reject_flag_next = 1'b1;
            end
          end
          if (!reject_flag_next && (ofs_gre + 7'd1) == {2'b00, gre_header_bytes}) begin
            parse_phase_next = PH_INNER;
          end
        end
        PH_INNER: begin
          if (ofs_inner == ETH_HDR_BYTES - 7'd1) begin
            complete_flag_next = 1'b1;
            parse_phase_next   = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ok                  = complete_flag_next && !reject_flag_next;
  assign result.tunnel_ok    = ok;
  assign result.outer_src_ip = ok ? captured_src_next : 32'd0;
  assign result.outer_dst_ip = ok ? captured_dst_next : 32'd0;

  // Clear all per-frame state after the final byte
  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_byte)) begin
      byte_position    <= 7'd0;
      parse_phase      <= PH_OUTER;
      ip_header_bytes  <= 6'd0;
      gre_header_bytes <= 5'd0;
      field_shift      <= 16'd0;
      captured_src     <= 32'd0;
      captured_dst     <= 32'd0;
      reject_flag      <= 1'b0;
      complete_flag    <= 1'b0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      parse_phase      <= parse_phase_next;
      ip_header_bytes  <= ip_header_bytes_next;
      gre_header_bytes <= gre_header_bytes_next;
      field_shift      <= field_shift_next;
      captured_src     <= captured_src_next;
      captured_dst     <= captured_dst_next;
      reject_flag      <= reject_flag_next;
      complete_flag    <= complete_flag_next;
    end
  end

endmodule

// File: hdl/gtp_out_stage.sv
module gtp_out_stage
  import gtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // [31:0] outer_src_ip, [63:32] outer_dst_ip
  output logic        m_tuser   // tunnel_ok
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= result.tunnel_ok;
      m_tdata <= {result.outer_dst_ip, result.outer_src_ip};
    end
  end

endmodule

// File: hdl/gre_tunnel_header_parser.sv
// Channel  Signals                                  Payload (lowest bit first)
// s        s_tvalid s_tready s_tdata[7:0] s_tlast   data_byte; tlast = last_byte
// m        m_tvalid m_tready m_tdata[63:0] m_tuser  outer_src_ip, outer_dst_ip;
//                                                   tuser = tunnel_ok
//
// One byte per cycle unless a final byte waits on a stalled output register.
// Path: input register, combinational parse update, output register (drives m_tvalid).
// rst is synchronous and clears both stage valids and all per-frame state.
// A stalled result holds only the byte that ends the next frame; other bytes
// keep flowing through the parser.
module gre_tunnel_header_parser
  import gtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] outer_src_ip, [63:32] outer_dst_ip
  output logic        m_tuser    // tunnel_ok
);

  logic    hold_vld;
  item_t   hold_item;
  logic    advance;
  logic    load;
  result_t result;

  // Advance unless a final byte must wait for the output register
  assign advance = hold_vld && (!hold_item.last_byte || !m_tvalid || m_tready);
  assign load    = advance && hold_item.last_byte;

  gtp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .advance   (advance),
    .hold_vld  (hold_vld),
    .hold_item (hold_item)
  );

  gtp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold_item),
    .result  (result)
  );

  gtp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`include "gre_tunnel_header_parser_assert.svh"

  `GTP_ASSERT_IMPLY(a_reject_zero_addr, clk, rst, m_tvalid && !m_tuser, m_tdata == 64'd0)
  `GTP_ASSERT_NEXT(a_last_gives_result, clk, rst, load, m_tvalid)
  `GTP_ASSERT_IMPLY(a_stall_only_on_last, clk, rst, !s_tready, hold_vld && hold_item.last_byte && m_tvalid && !m_tready)

endmodule

// File: dv/gre_tunnel_header_parser_test.sv
module gre_tunnel_header_parser_test;
  import gtp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_CYCLES = 11;

  localparam logic [7:0] GRE_FLAG_C = 8'h80;
  localparam logic [7:0] GRE_FLAG_K = 8'h20;
  localparam logic [7:0] GRE_FLAG_S = 8'h10;
  localparam logic [7:0] GRE_FLAGS_ALL = GRE_FLAG_C | GRE_FLAG_K | GRE_FLAG_S;
  localparam logic [7:0] GRE_FLAGS_IGNORED = 8'h4F;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef enum int {
    BREAK_OUTER_TYPE,
    BREAK_IHL,
    BREAK_PROTOCOL,
    BREAK_GRE_TYPE
  } frame_fault_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  int send_idle_pct = 16;
  int recv_idle_pct = 64;
  int hold_req = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;

  // Parser mirror
  logic [6:0]  pos;
  logic [2:0]  phase;
  logic [5:0]  ip_len;
  logic [4:0]  gre_len;
  logic [15:0] type_shift;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic        rejected;
  logic        inner_done;

  result_t    expected_results[$];
  logic [7:0] frame_bytes[$];

  gre_tunnel_header_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gre_tunnel_header_parser_test failed");
      $finish;
    end
  end

  task automatic clear_parser;
    pos = '0;
    phase = PH_OUTER;
    ip_len = '0;
    gre_len = '0;
    type_shift = '0;
    src_addr = '0;
    dst_addr = '0;
    rejected = 1'b0;
    inner_done = 1'b0;
  endtask

  // Advance the mirror by one accepted byte; queue a verdict on the last byte.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int         o;
    logic [3:0] ihl;
    logic [4:0] hdr_len;
    result_t    verdict;
    if (!rejected) begin
      case (phase)
        PH_OUTER: begin
          type_shift = {type_shift[7:0], b};
          if (pos == ETH_HDR_BYTES - 1) begin
            if (type_shift != TYPE_IPV4) rejected = 1'b1;
            else phase = PH_IP;
          end
        end
        PH_IP: begin
          o = int'(pos) - int'(ETH_HDR_BYTES);
          if (o == 0) begin
            ihl = b[3:0];
            if (ihl < IHL_MIN) rejected = 1'b1;
            else ip_len = {ihl, 2'b00};
          end else if (o == IP_PROTO_OFS) begin
            if (b != PROTO_GRE) rejected = 1'b1;
          end else if (o >= IP_SRC_FIRST && o <= IP_SRC_LAST) begin
            src_addr = {src_addr[23:0], b};
          end else if (o >= IP_DST_FIRST && o <= IP_DST_LAST) begin
            dst_addr = {dst_addr[23:0], b};
          end
          if (!rejected && o + 1 == int'(ip_len)) phase = PH_GRE;
        end
        PH_GRE: begin
          o = int'(pos) - int'(ETH_HDR_BYTES) - int'(ip_len);
          if (o == 0) begin
            hdr_len = GRE_BASE_BYTES;
            if ((b & GRE_FLAG_C) != 0) hdr_len = hdr_len + GRE_OPT_BYTES;
            if ((b & GRE_FLAG_K) != 0) hdr_len = hdr_len + GRE_OPT_BYTES;
            if ((b & GRE_FLAG_S) != 0) hdr_len = hdr_len + GRE_OPT_BYTES;
            gre_len = hdr_len;
          end else if (o == GRE_PROTO_HI || o == GRE_PROTO_LO) begin
            type_shift = {type_shift[7:0], b};
            if (o == GRE_PROTO_LO && type_shift != TYPE_TEB) rejected = 1'b1;
          end
          if (!rejected && o + 1 == int'(gre_len)) phase = PH_INNER;
        end
        PH_INNER: begin
          o = int'(pos) - int'(ETH_HDR_BYTES) - int'(ip_len) - int'(gre_len);
          if (o == ETH_HDR_BYTES - 1) begin
            inner_done = 1'b1;
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end
    if (pos < POS_MAX) pos = pos + 1'b1;
    if (last) begin
      verdict.tunnel_ok = inner_done && !rejected;
      verdict.outer_src_ip = verdict.tunnel_ok ? src_addr : '0;
      verdict.outer_dst_ip = verdict.tunnel_ok ? dst_addr : '0;
      expected_results.push_back(verdict);
      clear_parser();
    end
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    parse_byte(b, last);
  endtask

  task automatic send_frame;
    for (int i = 0; i < frame_bytes.size(); i++)
      offer_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    bytes_sent += frame_bytes.size();
    frames_sent++;
  endtask

  // Hold the sender until every queued verdict has come out.
  task automatic drain_results;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic build_tunnel_frame(input int ihl, input logic [7:0] flags,
                                    input logic [31:0] src, input logic [31:0] dst,
                                    input int extra);
    int         opt_bytes;
    logic [7:0] b;
    frame_bytes.delete();
    repeat (ETH_HDR_BYTES - 2) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(TYPE_IPV4[15:8]);
    frame_bytes.push_back(TYPE_IPV4[7:0]);
    for (int i = 0; i < ihl * 4; i++) begin
      b = 8'($urandom);
      if (i == 0) b = {4'($urandom_range(15)), 4'(ihl)};
      else if (i == IP_PROTO_OFS) b = PROTO_GRE;
      else if (i >= IP_SRC_FIRST && i <= IP_SRC_LAST) b = src[8 * (IP_SRC_LAST - i) +: 8];
      else if (i >= IP_DST_FIRST && i <= IP_DST_LAST) b = dst[8 * (IP_DST_LAST - i) +: 8];
      frame_bytes.push_back(b);
    end
    frame_bytes.push_back(flags);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(TYPE_TEB[15:8]);
    frame_bytes.push_back(TYPE_TEB[7:0]);
    opt_bytes = 0;
    if ((flags & GRE_FLAG_C) != 0) opt_bytes += GRE_OPT_BYTES;
    if ((flags & GRE_FLAG_K) != 0) opt_bytes += GRE_OPT_BYTES;
    if ((flags & GRE_FLAG_S) != 0) opt_bytes += GRE_OPT_BYTES;
    repeat (opt_bytes + ETH_HDR_BYTES + extra) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic build_noise_frame(input int len);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic break_frame(input frame_fault_e fault, input int ihl);
    int idx;
    case (fault)
      BREAK_OUTER_TYPE: idx = ETH_HDR_BYTES - 2 + $urandom_range(1);
      BREAK_PROTOCOL:   idx = ETH_HDR_BYTES + IP_PROTO_OFS;
      BREAK_GRE_TYPE:   idx = ETH_HDR_BYTES + ihl * 4 + GRE_PROTO_HI + $urandom_range(1);
      default:          idx = ETH_HDR_BYTES;
    endcase
    if (fault == BREAK_IHL)
      frame_bytes[idx][3:0] = 4'($urandom_range(IHL_MIN - 1));
    else
      frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic truncate_frame(input int len);
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
  endtask

  task automatic send_random_frame;
    int kind;
    int ihl;
    int extra;
    kind = $urandom_range(99);
    ihl = ($urandom_range(2) == 0) ? $urandom_range(IHL_MIN + 1, 15) : IHL_MIN;
    extra = ($urandom_range(19) == 0) ? $urandom_range(40, 100) : $urandom_range(6);
    build_tunnel_frame(ihl, 8'($urandom), $urandom, $urandom, extra);
    if (kind >= 90) build_noise_frame($urandom_range(1, 60));
    else if (kind >= 80) truncate_frame($urandom_range(1, frame_bytes.size() - 1));
    else if (kind >= 60) break_frame(frame_fault_e'($urandom_range(BREAK_GRE_TYPE)), ihl);
    send_frame();
  endtask

  task automatic test_directed_frames;
    send_idle_pct = 16;
    recv_idle_pct = 64;
    build_tunnel_frame(IHL_MIN, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_frame();
    // largest headers: the inner header ends on the last decision byte
    build_tunnel_frame(15, GRE_FLAGS_ALL, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_frame();
    build_tunnel_frame(IHL_MIN, GRE_FLAGS_IGNORED, $urandom, $urandom, 3);
    send_frame();
    build_tunnel_frame(7, GRE_FLAG_K, $urandom, $urandom, 1);
    send_frame();
    build_tunnel_frame(IHL_MIN, GRE_FLAG_S, $urandom, $urandom, 0);
    send_frame();
    build_tunnel_frame(IHL_MIN, 8'h00, $urandom, $urandom, 0);
    break_frame(BREAK_OUTER_TYPE, IHL_MIN);
    truncate_frame(ETH_HDR_BYTES + 4);
    send_frame();
    build_tunnel_frame(IHL_MIN, 8'h00, $urandom, $urandom, 0);
    frame_bytes[ETH_HDR_BYTES][3:0] = 4'd0;
    truncate_frame(ETH_HDR_BYTES + 10);
    send_frame();
    build_tunnel_frame(IHL_MIN, 8'h00, $urandom, $urandom, 0);
    frame_bytes[ETH_HDR_BYTES][3:0] = 4'(IHL_MIN - 1);
    truncate_frame(ETH_HDR_BYTES + 10);
    send_frame();
    build_tunnel_frame(IHL_MIN, 8'h00, $urandom, $urandom, 0);
    frame_bytes[ETH_HDR_BYTES + IP_PROTO_OFS] = PROTO_TCP;
    truncate_frame(ETH_HDR_BYTES + IP_PROTO_OFS + 6);
    send_frame();
    build_tunnel_frame(6, GRE_FLAG_C, $urandom, $urandom, 2);
    break_frame(BREAK_GRE_TYPE, 6);
    send_frame();
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    build_noise_frame(ETH_HDR_BYTES - 1);
    send_frame();
    // one byte short of the inner header
    build_tunnel_frame(IHL_MIN, 8'h00, $urandom, $urandom, 0);
    truncate_frame(frame_bytes.size() - 1);
    send_frame();
    build_tunnel_frame(8, GRE_FLAGS_ALL, $urandom, $urandom, 0);
    truncate_frame(ETH_HDR_BYTES + 8 * 4 + 6);
    send_frame();
    // past the position counter's saturation
    build_tunnel_frame(IHL_MIN, GRE_FLAG_K, $urandom, $urandom, 76);
    send_frame();
    build_noise_frame(20);
    send_frame();
    drain_results();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct,
                                    input int min_bytes, input int min_frames);
    int start_bytes;
    int start_frames;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_bytes = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < min_bytes || frames_sent - start_frames < min_frames)
      send_random_frame();
    drain_results();
  endtask

  // Stall the result side long enough that the parser backs up into its input.
  task automatic test_output_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    build_tunnel_frame(IHL_MIN, 8'h00, $urandom, $urandom, 0);
    send_frame();
    repeat (8) begin
      build_noise_frame($urandom_range(1, 3));
      send_frame();
    end
    drain_results();
  endtask

  initial begin : result_receiver
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: tunnel_ok %0b outer_src_ip %h outer_dst_ip %h",
               m_tuser, m_tdata[31:0], m_tdata[63:32]);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.tunnel_ok) begin
          $error("tunnel_ok: expected %0b, got %0b", want.tunnel_ok, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[31:0] !== want.outer_src_ip) begin
          $error("outer_src_ip: expected %h, got %h", want.outer_src_ip, m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[63:32] !== want.outer_dst_ip) begin
          $error("outer_dst_ip: expected %h, got %h", want.outer_dst_ip, m_tdata[63:32]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_random_frames(16, 64, 60, 1);
    test_random_frames(64, 16, 60, 1);
    test_random_frames(0, 0, 60, 1);
    test_output_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gre_tunnel_header_parser_test passed");
    end else begin
      $display("gre_tunnel_header_parser_test failed");
    end
    $finish;
  end

endmodule
